FILE: src/abs_pkg.sv
// shared types, constants and helpers of the branch and system unit
package abs_pkg;

	// geometry of the zero-line request, must be a power of two
	localparam int unsigned ZERO_LINE_BYTES = 64;
	localparam logic [63:0] ZERO_LINE_MASK = ~(64'(ZERO_LINE_BYTES) - 64'd1);

	// stream widths, padded to whole bytes
	localparam int unsigned IN_BITS = 228;
	localparam int unsigned IN_TDATA_W = 232;
	localparam int unsigned OUT_BITS = 271;
	localparam int unsigned OUT_TDATA_W = 272;

	localparam int unsigned CFG_INDEX_W = 3;

	typedef enum logic [2:0] {
		OC_CONTINUE = 3'd0,
		OC_BRANCH = 3'd1,
		OC_SYSCALL = 3'd2,
		OC_ICCOMMIT = 3'd3,
		OC_ICFLUSH = 3'd4,
		OC_ILLEGAL = 3'd5,
		OC_TRAP = 3'd6,
		OC_UNMODELLED = 3'd7
	} outcome_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_CACHE_TYPE = 3'd0,
		CFG_ZERO_BLOCK_ID = 3'd1,
		CFG_USER_ID_ACCESS = 3'd2,
		CFG_FP_CONTROL_MASK = 3'd3,
		CFG_FP_STATUS_MASK = 3'd4,
		CFG_IMAGE_BIAS = 3'd5
	} cfg_index_t;

	// encoding classes: mask and match value
	localparam logic [31:0] B_MASK = 32'h7C00_0000;
	localparam logic [31:0] B_VAL = 32'h1400_0000;
	localparam logic [31:0] BCOND_MASK = 32'hFF00_0000;
	localparam logic [31:0] BCOND_VAL = 32'h5400_0000;
	localparam logic [31:0] CB_MASK = 32'h7E00_0000;
	localparam logic [31:0] CB_VAL = 32'h3400_0000;
	localparam logic [31:0] TB_VAL = 32'h3600_0000;
	localparam logic [31:0] BREG_MASK = 32'hFE00_0000;
	localparam logic [31:0] BREG_VAL = 32'hD600_0000;
	localparam logic [31:0] EXC_MASK = 32'hFF00_0000;
	localparam logic [31:0] EXC_VAL = 32'hD400_0000;
	localparam logic [31:0] HINT_MASK = 32'hFFFF_F01F;
	localparam logic [31:0] HINT_VAL = 32'hD503_201F;
	localparam logic [31:0] BARRIER_VAL = 32'hD503_301F;
	localparam logic [31:0] SYS_RT_MASK = 32'hFFFF_FFE0;
	localparam logic [31:0] DC_CVAU_VAL = 32'hD50B_7B20;
	localparam logic [31:0] IC_IVAU_VAL = 32'hD50B_7520;
	localparam logic [31:0] DC_ZVA_VAL = 32'hD50B_7420;
	localparam logic [31:0] MSR_IMM_MASK = 32'hFFF8_F01F;
	localparam logic [31:0] MSR_IMM_VAL = 32'hD500_401F;
	localparam logic [31:0] SYSREG_MASK = 32'hFFD0_0000;
	localparam logic [31:0] SYSREG_VAL = 32'hD510_0000;
	localparam logic [15:0] ID_EL1_READ_HI = 16'hD538;

	// system register accesses, rt cleared
	localparam logic [31:0] MRS_CTR = 32'hD53B_0020;
	localparam logic [31:0] MRS_DCZID = 32'hD53B_00E0;
	localparam logic [31:0] MRS_TPIDR = 32'hD53B_D040;
	localparam logic [31:0] MRS_TPIDRRO = 32'hD53B_D060;
	localparam logic [31:0] MSR_TPIDR = 32'hD51B_D040;
	localparam logic [31:0] MRS_NZCV = 32'hD53B_4200;
	localparam logic [31:0] MSR_NZCV = 32'hD51B_4200;
	localparam logic [31:0] MRS_DAIF = 32'hD53B_4220;
	localparam logic [31:0] MSR_DAIF = 32'hD51B_4220;
	localparam logic [31:0] MRS_FPCR = 32'hD53B_4400;
	localparam logic [31:0] MSR_FPCR = 32'hD51B_4400;
	localparam logic [31:0] MRS_FPSR = 32'hD53B_4420;
	localparam logic [31:0] MSR_FPSR = 32'hD51B_4420;
	localparam logic [31:0] MRS_CNTFRQ = 32'hD53B_E000;
	localparam logic [31:0] MRS_CNTPCT = 32'hD53B_E020;
	localparam logic [31:0] MRS_CNTVCT = 32'hD53B_E040;
	localparam logic [31:0] MRS_CNTVCTSS = 32'hD53B_E0C0;

	localparam logic [63:0] CNT_FREQ_HZ = 64'd1000000000;

	typedef struct packed {
		logic [31:0] instruction;
		logic [63:0] current_pc;
		logic [63:0] operand_value;
		logic [3:0] flags_in;
		logic [63:0] time_now;
	} item_t;

	typedef struct packed {
		logic [63:0] next_pc;
		outcome_t outcome;
		logic reg_write;
		logic [4:0] reg_index;
		logic [63:0] reg_value;
		logic flags_write;
		logic [3:0] flags_out;
		logic [63:0] fault_address;
		logic [63:0] line_address;
		logic zero_line;
	} result_t;

	typedef struct packed {
		logic [63:0] cache_type_value;
		logic [63:0] zero_block_id_value;
		logic user_id_access;
		logic [31:0] fp_control_mask;
		logic [31:0] fp_status_mask;
		logic [63:0] image_bias;
	} cfg_t;

	typedef struct packed {
		logic [63:0] thread_pointer;
		logic [31:0] fp_control;
		logic [31:0] fp_status;
	} arch_state_t;

	typedef struct packed {
		logic tp_we;
		logic fpcr_we;
		logic fpsr_we;
		logic [63:0] tp;
		logic [31:0] fpcr;
		logic [31:0] fpsr;
	} state_upd_t;

	// condition code evaluation, flags are n z c v in bits 3..0
	function automatic logic cond_holds(input logic [3:0] cond, input logic [3:0] f);
		logic r;
		logic always_true;
		r = 1'b0;
		always_true = 1'b0;
		case (cond[3:1])
			3'd0: r = f[2];
			3'd1: r = f[1];
			3'd2: r = f[3];
			3'd3: r = f[0];
			3'd4: r = f[1] & ~f[2];
			3'd5: r = (f[3] == f[0]);
			3'd6: r = (f[3] == f[0]) & ~f[2];
			default: always_true = 1'b1;
		endcase
		return always_true | (cond[0] ? ~r : r);
	endfunction

endpackage

FILE: src/abs_exec.sv
// decode and execute of one branch, exception or system instruction
module abs_exec (
	input abs_pkg::item_t item,
	input abs_pkg::cfg_t cfg,
	input abs_pkg::arch_state_t st,
	output abs_pkg::result_t res,
	output abs_pkg::state_upd_t upd
);

	logic [31:0] w;
	logic [63:0] pc;
	logic [63:0] opv;
	logic [63:0] guest_pc;
	logic [63:0] ret_addr;
	logic [63:0] pc4;
	logic [63:0] off26;
	logic [63:0] off19;
	logic [63:0] off14;
	logic [5:0] tbit;
	logic cb_zero;

	assign w = item.instruction;
	assign pc = item.current_pc;
	assign opv = item.operand_value;
	assign guest_pc = pc - cfg.image_bias;
	assign ret_addr = guest_pc + 64'd4;
	assign pc4 = pc + 64'd4;
	assign off26 = {{36{w[25]}}, w[25:0], 2'b00};
	assign off19 = {{43{w[23]}}, w[23:5], 2'b00};
	assign off14 = {{48{w[18]}}, w[18:5], 2'b00};
	assign tbit = {w[31], w[23:19]};
	assign cb_zero = w[31] ? (opv == 64'd0) : (opv[31:0] == 32'd0);

	always_comb begin
		logic known;
		logic [63:0] rval;
		logic [31:0] sreg;
		known = 1'b1;
		rval = 64'd0;
		sreg = w & abs_pkg::SYS_RT_MASK;
		res = '0;
		res.next_pc = pc4;
		res.outcome = abs_pkg::OC_CONTINUE;
		upd = '0;
		upd.tp = opv;
		upd.fpcr = opv[31:0] & cfg.fp_control_mask;
		upd.fpsr = opv[31:0] & cfg.fp_status_mask;

		if ((w & abs_pkg::B_MASK) == abs_pkg::B_VAL) begin
			res.next_pc = pc + off26;
			res.outcome = abs_pkg::OC_BRANCH;
			if (w[31]) begin
				res.reg_write = 1'b1;
				res.reg_index = 5'd30;
				res.reg_value = ret_addr;
			end
		end else if ((w & abs_pkg::BCOND_MASK) == abs_pkg::BCOND_VAL) begin
			res.next_pc = abs_pkg::cond_holds(w[3:0], item.flags_in) ? pc + off19 : pc4;
			res.outcome = abs_pkg::OC_BRANCH;
		end else if ((w & abs_pkg::CB_MASK) == abs_pkg::CB_VAL) begin
			res.next_pc = (w[24] ? ~cb_zero : cb_zero) ? pc + off19 : pc4;
			res.outcome = abs_pkg::OC_BRANCH;
		end else if ((w & abs_pkg::CB_MASK) == abs_pkg::TB_VAL) begin
			res.next_pc = (w[24] ? opv[tbit] : ~opv[tbit]) ? pc + off14 : pc4;
			res.outcome = abs_pkg::OC_BRANCH;
		end else if ((w & abs_pkg::BREG_MASK) == abs_pkg::BREG_VAL) begin
			if (w[20:16] != 5'd31 || w[15:10] != 6'd0 || w[4:0] != 5'd0
					|| w[24:21] > 4'd2) begin
				res.next_pc = pc;
				res.outcome = abs_pkg::OC_UNMODELLED;
				res.fault_address = guest_pc;
			end else begin
				res.next_pc = opv;
				res.outcome = abs_pkg::OC_BRANCH;
				if (w[24:21] == 4'd1) begin
					res.reg_write = 1'b1;
					res.reg_index = 5'd30;
					res.reg_value = ret_addr;
				end
			end
		end else if ((w & abs_pkg::EXC_MASK) == abs_pkg::EXC_VAL) begin
			res.next_pc = pc;
			if (w[23:21] == 3'd0 && w[1:0] == 2'b01) begin
				res.outcome = abs_pkg::OC_SYSCALL;
			end else begin
				res.outcome = (w[23:21] == 3'd1) ? abs_pkg::OC_TRAP : abs_pkg::OC_ILLEGAL;
				res.fault_address = guest_pc;
			end
		end else if ((w & abs_pkg::HINT_MASK) == abs_pkg::HINT_VAL) begin
			res.outcome = abs_pkg::OC_CONTINUE;
		end else if ((w & abs_pkg::HINT_MASK) == abs_pkg::BARRIER_VAL) begin
			// isb commits fetched code, other barriers fall through
			res.outcome = (w[7:5] == 3'd6) ? abs_pkg::OC_ICCOMMIT : abs_pkg::OC_CONTINUE;
		end else if (sreg == abs_pkg::DC_CVAU_VAL) begin
			res.outcome = abs_pkg::OC_CONTINUE;
		end else if (sreg == abs_pkg::IC_IVAU_VAL) begin
			res.line_address = opv;
			res.outcome = abs_pkg::OC_ICFLUSH;
		end else if (sreg == abs_pkg::DC_ZVA_VAL) begin
			res.line_address = opv & abs_pkg::ZERO_LINE_MASK;
			res.zero_line = 1'b1;
		end else if ((w & abs_pkg::MSR_IMM_MASK) == abs_pkg::MSR_IMM_VAL) begin
			if (w[18:16] == 3'd0 || (w[18:16] == 3'd3 && w[7:5] == 3'd3)) begin
				res.next_pc = pc;
				res.outcome = abs_pkg::OC_UNMODELLED;
				res.fault_address = guest_pc;
			end
		end else if ((w & abs_pkg::SYSREG_MASK) == abs_pkg::SYSREG_VAL) begin
			if (w[21] && w[31:16] == abs_pkg::ID_EL1_READ_HI && !cfg.user_id_access) begin
				res.next_pc = pc;
				res.outcome = abs_pkg::OC_ILLEGAL;
				res.fault_address = guest_pc;
			end else begin
				case (sreg)
					abs_pkg::MRS_CTR: rval = cfg.cache_type_value;
					abs_pkg::MRS_DCZID: rval = cfg.zero_block_id_value;
					abs_pkg::MRS_TPIDR,
					abs_pkg::MRS_TPIDRRO: rval = st.thread_pointer;
					abs_pkg::MSR_TPIDR: upd.tp_we = 1'b1;
					abs_pkg::MRS_NZCV: rval = {32'd0, item.flags_in, 28'd0};
					abs_pkg::MSR_NZCV: begin
						res.flags_write = 1'b1;
						res.flags_out = opv[31:28];
					end
					abs_pkg::MRS_DAIF: rval = 64'd0;
					abs_pkg::MSR_DAIF: rval = 64'd0;
					abs_pkg::MRS_FPCR: rval = {32'd0, st.fp_control};
					abs_pkg::MSR_FPCR: upd.fpcr_we = 1'b1;
					abs_pkg::MRS_FPSR: rval = {32'd0, st.fp_status};
					abs_pkg::MSR_FPSR: upd.fpsr_we = 1'b1;
					abs_pkg::MRS_CNTFRQ: rval = abs_pkg::CNT_FREQ_HZ;
					abs_pkg::MRS_CNTPCT,
					abs_pkg::MRS_CNTVCT,
					abs_pkg::MRS_CNTVCTSS: rval = item.time_now;
					default: known = 1'b0;
				endcase
				if (!known) begin
					res.next_pc = pc;
					res.outcome = abs_pkg::OC_UNMODELLED;
					res.fault_address = guest_pc;
				end else if (w[21]) begin
					res.reg_write = 1'b1;
					res.reg_index = w[4:0];
					res.reg_value = rval;
				end
			end
		end else begin
			res.next_pc = pc;
			res.outcome = abs_pkg::OC_UNMODELLED;
			res.fault_address = guest_pc;
		end
	end

endmodule

FILE: src/aarch64_branch_system_unit.sv
// top level of the a64 branch, exception and system instruction unit
// a beat accepted into the input register is executed and its result held in the result register, which drives m_tvalid
// throughput: one instruction per cycle while m_tready holds, set by the single
// decode/execute pass between the input register and the result register
// while a result waits for m_tready the input register takes one more beat, then stalls
// reset: clears both valid flags, thread pointer, fpcr and fpsr, and loads config defaults
module aarch64_branch_system_unit (
	input logic clk,
	input logic arst_n,
	// input stream
	input logic s_tvalid,
	output logic s_tready,
	// instruction[31:0], current_pc[95:32], operand_value[159:96], flags_in[163:160],
	// time_now[227:164], zero pad above
	input logic [abs_pkg::IN_TDATA_W-1:0] s_tdata,
	// result stream
	output logic m_tvalid,
	input logic m_tready,
	// next_pc[63:0], outcome[66:64], reg_write[67], reg_index[72:68], reg_value[136:73],
	// flags_write[137], flags_out[141:138], fault_address[205:142],
	// line_address[269:206], zero_line[270], zero pad above
	output logic [abs_pkg::OUT_TDATA_W-1:0] m_tdata,
	// configuration write channel
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [abs_pkg::CFG_INDEX_W-1:0] cfg_index,
	input logic [63:0] cfg_data
);

	abs_pkg::item_t item_s1;
	logic valid_s1;
	abs_pkg::result_t result_s2;
	logic valid_s2;

	abs_pkg::cfg_t cfg_q;
	abs_pkg::arch_state_t state_q;

	abs_pkg::result_t res;
	abs_pkg::state_upd_t upd;

	logic adv_s2;
	logic take_in;

	// result register frees when empty or drained this cycle
	assign adv_s2 = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || adv_s2;
	assign take_in = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	abs_exec u_exec (
		.item(item_s1),
		.cfg(cfg_q),
		.st(state_q),
		.res(res),
		.upd(upd)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			item_s1.instruction <= s_tdata[31:0];
			item_s1.current_pc <= s_tdata[95:32];
			item_s1.operand_value <= s_tdata[159:96];
			item_s1.flags_in <= s_tdata[163:160];
			item_s1.time_now <= s_tdata[227:164];
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			result_s2 <= res;
		end
	end

	// architectural state commits as the instruction leaves the execute pass,
	// so the next instruction in the input register already sees it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (adv_s2 && valid_s1) begin
			if (upd.tp_we) begin
				state_q.thread_pointer <= upd.tp;
			end
			if (upd.fpcr_we) begin
				state_q.fp_control <= upd.fpcr;
			end
			if (upd.fpsr_we) begin
				state_q.fp_status <= upd.fpsr;
			end
		end
	end

	// configuration registers, indexes past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cache_type_value <= 64'd0;
			cfg_q.zero_block_id_value <= 64'd4;
			cfg_q.user_id_access <= 1'b0;
			cfg_q.fp_control_mask <= '1;
			cfg_q.fp_status_mask <= '1;
			cfg_q.image_bias <= 64'd0;
		end else if (cfg_valid && cfg_ready) begin
			case (abs_pkg::cfg_index_t'(cfg_index))
				abs_pkg::CFG_CACHE_TYPE: cfg_q.cache_type_value <= cfg_data;
				abs_pkg::CFG_ZERO_BLOCK_ID: cfg_q.zero_block_id_value <= cfg_data;
				abs_pkg::CFG_USER_ID_ACCESS: cfg_q.user_id_access <= cfg_data[0];
				abs_pkg::CFG_FP_CONTROL_MASK: cfg_q.fp_control_mask <= cfg_data[31:0];
				abs_pkg::CFG_FP_STATUS_MASK: cfg_q.fp_status_mask <= cfg_data[31:0];
				abs_pkg::CFG_IMAGE_BIAS: cfg_q.image_bias <= cfg_data;
				default: ;
			endcase
		end
	end

	// pack the result beat, lowest field first
	assign m_tvalid = valid_s2;
	assign m_tdata = {
		1'b0,
		result_s2.zero_line,
		result_s2.line_address,
		result_s2.fault_address,
		result_s2.flags_out,
		result_s2.flags_write,
		result_s2.reg_value,
		result_s2.reg_index,
		result_s2.reg_write,
		result_s2.outcome,
		result_s2.next_pc
	};

endmodule

FILE: src/abs_checker.sv
// port-level checks of the branch and system unit, with its bind
module abs_props (
	input logic clk,
	input logic arst_n,
	input logic m_tvalid,
	input logic m_tready,
	input logic [abs_pkg::OUT_TDATA_W-1:0] m_tdata
);

	// a stalled result beat holds its data
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	// register value is zero unless a register is written
	a_rval_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[67] |-> m_tdata[136:73] == 64'd0)
		else $error("register value without register write");

	// a zero-line request is a plain continue with an aligned line
	a_zero_line: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[270] |-> m_tdata[66:64] == abs_pkg::OC_CONTINUE
			&& m_tdata[211:206] == 6'd0 && !m_tdata[67])
		else $error("malformed zero-line request");

	// flag writes come only from msr nzcv, which writes no register
	a_flags_write: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[137] |-> m_tdata[66:64] == abs_pkg::OC_CONTINUE
			&& !m_tdata[67] && !m_tdata[270])
		else $error("flags write with other side effects");

	// syscalls and faults never write a register
	a_no_write_on_stop: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[66:64] == abs_pkg::OC_SYSCALL
			|| m_tdata[66:64] == abs_pkg::OC_TRAP
			|| m_tdata[66:64] == abs_pkg::OC_ILLEGAL
			|| m_tdata[66:64] == abs_pkg::OC_UNMODELLED) |-> !m_tdata[67])
		else $error("register write on a stopping outcome");

endmodule

bind aarch64_branch_system_unit abs_props u_abs_props (
	.clk(clk),
	.arst_n(arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata(m_tdata)
);

FILE: verif/abs_checker.sv
// result checker for the branch and system unit: predicts each instruction and compares beats
`timescale 1ns / 1ps

module abs_checker import abs_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	input logic s_tready,
	input logic [IN_TDATA_W-1:0] s_tdata,
	input logic m_tvalid,
	input logic m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata,
	input logic cfg_valid,
	input logic cfg_ready,
	input logic [CFG_INDEX_W-1:0] cfg_index,
	input logic [63:0] cfg_data,
	output int mismatches,
	output int pending
);

	// shadow copies of the configuration and the architectural state
	cfg_t cfg;
	logic [63:0] thread_ptr;
	logic [31:0] fp_control;
	logic [31:0] fp_status;

	result_t expected_results[$];
	result_t want;
	result_t got;
	item_t insn;

	task automatic check_field(input string name, input logic [63:0] exp_v,
			input logic [63:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %h, got %h", name, exp_v, act_v);
			mismatches++;
		end
	endtask

	// executes one instruction against the shadow state and returns its result beat
	function automatic result_t execute_insn(input item_t it);
		result_t r;
		logic [31:0] w;
		logic [63:0] pc;
		logic [63:0] opv;
		logic [63:0] gpc;
		logic [63:0] offs;
		logic [63:0] rval;
		logic [5:0] bitpos;
		logic hit;
		logic take;
		logic is_zero;
		logic known;
		logic rw;
		w = it.instruction;
		pc = it.current_pc;
		opv = it.operand_value;
		gpc = pc - cfg.image_bias;
		r = '0;
		r.next_pc = pc + 64'd4;
		r.outcome = OC_CONTINUE;
		rw = 1'b0;
		rval = '0;
		if ((w & B_MASK) == B_VAL) begin
			r.next_pc = pc + {{36{w[25]}}, w[25:0], 2'b00};
			// bl links
			if (w[31]) begin
				rw = 1'b1;
				r.reg_index = 5'd30;
				rval = gpc + 64'd4;
			end
			r.outcome = OC_BRANCH;
		end else if ((w & BCOND_MASK) == BCOND_VAL) begin
			offs = {{43{w[23]}}, w[23:5], 2'b00};
			case (w[3:1])
				3'd0: hit = it.flags_in[2];
				3'd1: hit = it.flags_in[1];
				3'd2: hit = it.flags_in[3];
				3'd3: hit = it.flags_in[0];
				3'd4: hit = it.flags_in[1] & ~it.flags_in[2];
				3'd5: hit = (it.flags_in[3] == it.flags_in[0]);
				3'd6: hit = (it.flags_in[3] == it.flags_in[0]) & ~it.flags_in[2];
				default: hit = 1'b1;
			endcase
			// al and nv always hold
			take = (w[3:1] == 3'd7) ? 1'b1 : (w[0] ? ~hit : hit);
			if (take)
				r.next_pc = pc + offs;
			r.outcome = OC_BRANCH;
		end else if ((w & CB_MASK) == CB_VAL) begin
			offs = {{43{w[23]}}, w[23:5], 2'b00};
			is_zero = w[31] ? (opv == 64'd0) : (opv[31:0] == 32'd0);
			take = w[24] ? ~is_zero : is_zero;
			if (take)
				r.next_pc = pc + offs;
			r.outcome = OC_BRANCH;
		end else if ((w & CB_MASK) == TB_VAL) begin
			bitpos = {w[31], w[23:19]};
			offs = {{48{w[18]}}, w[18:5], 2'b00};
			take = w[24] ? opv[bitpos] : ~opv[bitpos];
			if (take)
				r.next_pc = pc + offs;
			r.outcome = OC_BRANCH;
		end else if ((w & BREG_MASK) == BREG_VAL) begin
			// only plain br, blr and ret are modelled
			if (w[20:16] != 5'd31 || w[15:10] != 6'd0 || w[4:0] != 5'd0 || w[24:21] > 4'd2) begin
				r.next_pc = pc;
				r.outcome = OC_UNMODELLED;
				r.fault_address = gpc;
			end else begin
				r.next_pc = opv;
				if (w[24:21] == 4'd1) begin
					rw = 1'b1;
					r.reg_index = 5'd30;
					rval = gpc + 64'd4;
				end
				r.outcome = OC_BRANCH;
			end
		end else if ((w & EXC_MASK) == EXC_VAL) begin
			r.next_pc = pc;
			if (w[23:21] == 3'd0 && w[1:0] == 2'b01) begin
				r.outcome = OC_SYSCALL;
			end else begin
				r.outcome = (w[23:21] == 3'd1) ? OC_TRAP : OC_ILLEGAL;
				r.fault_address = gpc;
			end
		end else if ((w & HINT_MASK) == HINT_VAL) begin
			// hints fall through
		end else if ((w & HINT_MASK) == BARRIER_VAL) begin
			if (w[7:5] == 3'd6)
				r.outcome = OC_ICCOMMIT;
		end else if ((w & SYS_RT_MASK) == DC_CVAU_VAL) begin
			// clean to unification is a no-op here
		end else if ((w & SYS_RT_MASK) == IC_IVAU_VAL) begin
			r.line_address = opv;
			r.outcome = OC_ICFLUSH;
		end else if ((w & SYS_RT_MASK) == DC_ZVA_VAL) begin
			r.line_address = opv & ~(64'(ZERO_LINE_BYTES) - 64'd1);
			r.zero_line = 1'b1;
		end else if ((w & MSR_IMM_MASK) == MSR_IMM_VAL) begin
			if (w[18:16] == 3'd0 || (w[18:16] == 3'd3 && w[7:5] == 3'd3)) begin
				r.next_pc = pc;
				r.outcome = OC_UNMODELLED;
				r.fault_address = gpc;
			end
		end else if ((w & SYSREG_MASK) == SYSREG_VAL) begin
			if (w[21] && w[31:16] == ID_EL1_READ_HI && !cfg.user_id_access) begin
				r.next_pc = pc;
				r.outcome = OC_ILLEGAL;
				r.fault_address = gpc;
			end else begin
				known = 1'b1;
				case (w & SYS_RT_MASK)
					MRS_CTR: rval = cfg.cache_type_value;
					MRS_DCZID: rval = cfg.zero_block_id_value;
					MRS_TPIDR, MRS_TPIDRRO: rval = thread_ptr;
					MSR_TPIDR: thread_ptr = opv;
					MRS_NZCV: rval = {32'd0, it.flags_in, 28'd0};
					MSR_NZCV: begin
						r.flags_write = 1'b1;
						r.flags_out = opv[31:28];
					end
					MRS_DAIF: rval = '0;
					MSR_DAIF: begin
						// writes to daif are dropped
					end
					MRS_FPCR: rval = {32'd0, fp_control};
					MSR_FPCR: fp_control = opv[31:0] & cfg.fp_control_mask;
					MRS_FPSR: rval = {32'd0, fp_status};
					MSR_FPSR: fp_status = opv[31:0] & cfg.fp_status_mask;
					MRS_CNTFRQ: rval = CNT_FREQ_HZ;
					MRS_CNTPCT, MRS_CNTVCT, MRS_CNTVCTSS: rval = it.time_now;
					default: known = 1'b0;
				endcase
				if (!known) begin
					rval = '0;
					r.next_pc = pc;
					r.outcome = OC_UNMODELLED;
					r.fault_address = gpc;
				end else if (w[21]) begin
					rw = 1'b1;
					r.reg_index = w[4:0];
				end
			end
		end else begin
			r.next_pc = pc;
			r.outcome = OC_UNMODELLED;
			r.fault_address = gpc;
		end
		r.reg_write = rw;
		r.reg_value = rw ? rval : 64'd0;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.cache_type_value = '0;
			cfg.zero_block_id_value = 64'd4;
			cfg.user_id_access = 1'b0;
			cfg.fp_control_mask = '1;
			cfg.fp_status_mask = '1;
			cfg.image_bias = '0;
			thread_ptr = '0;
			fp_control = '0;
			fp_status = '0;
			expected_results.delete();
			mismatches = 0;
			pending <= 0;
		end else begin
			// result side first, so a beat can never match the instruction of this edge
			if (m_tvalid && m_tready) begin
				got.next_pc = m_tdata[63:0];
				got.outcome = outcome_t'(m_tdata[66:64]);
				got.reg_write = m_tdata[67];
				got.reg_index = m_tdata[72:68];
				got.reg_value = m_tdata[136:73];
				got.flags_write = m_tdata[137];
				got.flags_out = m_tdata[141:138];
				got.fault_address = m_tdata[205:142];
				got.line_address = m_tdata[269:206];
				got.zero_line = m_tdata[270];
				if (expected_results.size() == 0) begin
					$error("result beat with no instruction outstanding");
					mismatches++;
				end else begin
					want = expected_results.pop_front();
					check_field("next_pc", want.next_pc, got.next_pc);
					check_field("outcome", 64'(want.outcome), 64'(got.outcome));
					check_field("reg_write", 64'(want.reg_write), 64'(got.reg_write));
					check_field("reg_index", 64'(want.reg_index), 64'(got.reg_index));
					check_field("reg_value", want.reg_value, got.reg_value);
					check_field("flags_write", 64'(want.flags_write), 64'(got.flags_write));
					check_field("flags_out", 64'(want.flags_out), 64'(got.flags_out));
					check_field("fault_address", want.fault_address, got.fault_address);
					check_field("line_address", want.line_address, got.line_address);
					check_field("zero_line", 64'(want.zero_line), 64'(got.zero_line));
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index_t'(cfg_index))
					CFG_CACHE_TYPE: cfg.cache_type_value = cfg_data;
					CFG_ZERO_BLOCK_ID: cfg.zero_block_id_value = cfg_data;
					CFG_USER_ID_ACCESS: cfg.user_id_access = cfg_data[0];
					CFG_FP_CONTROL_MASK: cfg.fp_control_mask = cfg_data[31:0];
					CFG_FP_STATUS_MASK: cfg.fp_status_mask = cfg_data[31:0];
					CFG_IMAGE_BIAS: cfg.image_bias = cfg_data;
					default: begin
					end
				endcase
			end
			if (s_tvalid && s_tready) begin
				insn.instruction = s_tdata[31:0];
				insn.current_pc = s_tdata[95:32];
				insn.operand_value = s_tdata[159:96];
				insn.flags_in = s_tdata[163:160];
				insn.time_now = s_tdata[227:164];
				expected_results.push_back(execute_insn(insn));
			end
			pending <= expected_results.size();
		end
	end

endmodule

FILE: verif/tb.sv
// testbench top for the branch and system unit: stimulus, flow control and verdict
`timescale 1ns / 1ps

module tb;
	import abs_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int CHUNK_ITEMS = 150;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [IN_TDATA_W-1:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [63:0] cfg_data;

	int mismatches;
	int pending;
	int send_idle_pct;
	int recv_idle_pct;
	int hold_cycles;
	int cycle_count;

	aarch64_branch_system_unit i_dut (
		.clk,
		.arst_n,
		.s_tvalid,
		.s_tready,
		.s_tdata,
		.m_tvalid,
		.m_tready,
		.m_tdata,
		.cfg_valid,
		.cfg_ready,
		.cfg_index,
		.cfg_data
	);

	abs_checker i_checker (
		.clk,
		.arst_n,
		.s_tvalid,
		.s_tready,
		.s_tdata,
		.m_tvalid,
		.m_tready,
		.m_tdata,
		.cfg_valid,
		.cfg_ready,
		.cfg_index,
		.cfg_data,
		.mismatches,
		.pending
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// result side: random backpressure, or a long hold-off when asked for
	initial begin
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				m_tready <= 1'b0;
				hold_cycles--;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// watchdog
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	function automatic item_t make_item(input logic [31:0] w, input logic [63:0] pc,
			input logic [63:0] opv, input logic [3:0] f);
		item_t it;
		it.instruction = w;
		it.current_pc = pc;
		it.operand_value = opv;
		it.flags_in = f;
		it.time_now = {$urandom, $urandom};
		return it;
	endfunction

	// offers one instruction beat, with random idle cycles ahead of it
	task automatic send_insn(input item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {{(IN_TDATA_W - IN_BITS){1'b0}}, it.time_now, it.flags_in,
			it.operand_value, it.current_pc, it.instruction};
		do @(posedge clk); while (!s_tready);
	endtask

	// stop offering and wait until every result beat is back
	task automatic wait_for_results();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic write_reg(input cfg_index_t idx, input logic [63:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	initial begin
		cfg_t setting;
		logic [31:0] w;
		logic [31:0] r32;
		logic [63:0] opv;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_CACHE_TYPE;
		cfg_data = '0;
		hold_cycles = 0;
		send_idle_pct = 33;
		recv_idle_pct = 85;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, run with the configuration defaults
		// branch offsets at both extremes, pc wrapping
		send_insn(make_item(B_VAL | 32'h01FF_FFFF, 64'd0, 64'd0, 4'h0));
		send_insn(make_item(32'h8000_0000 | B_VAL | 32'h0200_0000, '1 - 64'd3, '1, 4'hF));
		send_insn(make_item(BCOND_VAL | 32'h00FF_FFE0, 64'h1000, 64'd0, 4'h4));
		// bc with the always condition and the most negative offset
		send_insn(make_item(BCOND_VAL | 32'h0080_001E, 64'h2000, 64'd0, 4'h0));
		send_insn(make_item(32'h8000_0000 | CB_VAL | 32'h20, 64'h3000, 64'd0, 4'h0));
		// tbz on bit 63 and tbnz on bit 0
		send_insn(make_item(32'h8000_0000 | TB_VAL | 32'h00F8_0020, 64'h4000,
			64'h8000_0000_0000_0000, 4'h0));
		send_insn(make_item(TB_VAL | 32'h0100_0020, 64'h5000, 64'd1, 4'h0));
		// br, blr, ret and a pointer-authenticated return
		send_insn(make_item(BREG_VAL | 32'h001F_0000, 64'h6000, '1, 4'h0));
		send_insn(make_item(BREG_VAL | 32'h003F_0020, 64'h7000, 64'h1234, 4'h0));
		send_insn(make_item(BREG_VAL | 32'h005F_03C0, 64'h8000, 64'h8004, 4'h0));
		send_insn(make_item(BREG_VAL | 32'h005F_0BFF, 64'h9000, 64'h8004, 4'h0));
		// svc, brk and a hypervisor call
		send_insn(make_item(EXC_VAL | 32'h1, 64'hA000, 64'd0, 4'h0));
		send_insn(make_item(EXC_VAL | 32'h0020_0000, 64'hB000, 64'd0, 4'h0));
		send_insn(make_item(EXC_VAL | 32'h2, 64'hC000, 64'd0, 4'h0));
		// nop, isb, ic ivau, dc zva
		send_insn(make_item(HINT_VAL, 64'hD000, 64'd0, 4'h0));
		send_insn(make_item(BARRIER_VAL | 32'h0000_0FC0, 64'hE000, 64'd0, 4'h0));
		send_insn(make_item(IC_IVAU_VAL | 32'h5, 64'hF000, '1, 4'h0));
		send_insn(make_item(DC_ZVA_VAL, 64'h1_0000, '1, 4'h0));
		// msr immediate with op1 zero is not modelled
		send_insn(make_item(MSR_IMM_VAL | 32'h80, 64'h1_1000, 64'd0, 4'h0));
		// nzcv written, then read with other input flags, fpsr written with all bits
		send_insn(make_item(MSR_NZCV | 32'h3, 64'h1_2000, 64'hF000_0000, 4'h0));
		send_insn(make_item(MRS_NZCV | 32'h4, 64'h1_3000, 64'd0, 4'hA));
		send_insn(make_item(MSR_FPSR, 64'h1_4000, '1, 4'h0));
		// el1 id read trapped, counter read, all-zero word
		send_insn(make_item({ID_EL1_READ_HI, 16'h0000}, 64'h1_5000, 64'd0, 4'h0));
		send_insn(make_item(MRS_CNTVCT | 32'h1, 64'h1_6000, 64'd0, 4'h0));
		send_insn(make_item(32'h0000_0000, 64'h1_7000, 64'd0, 4'h0));

		// random part in chunks, each with its own configuration
		for (int chunk = 0; chunk < 6; chunk++) begin
			wait_for_results();
			case (chunk)
				0: setting = '0;
				1: setting = '1;
				default: begin
					setting.cache_type_value = {$urandom, $urandom};
					setting.zero_block_id_value = {$urandom, $urandom};
					setting.user_id_access = $urandom_range(1);
					setting.fp_control_mask = $urandom;
					setting.fp_status_mask = $urandom;
					setting.image_bias = {$urandom, $urandom};
				end
			endcase
			write_reg(CFG_CACHE_TYPE, setting.cache_type_value);
			write_reg(CFG_ZERO_BLOCK_ID, setting.zero_block_id_value);
			write_reg(CFG_USER_ID_ACCESS, {63'd0, setting.user_id_access});
			write_reg(CFG_FP_CONTROL_MASK, {32'd0, setting.fp_control_mask});
			write_reg(CFG_FP_STATUS_MASK, {32'd0, setting.fp_status_mask});
			write_reg(CFG_IMAGE_BIAS, setting.image_bias);
			cfg_valid <= 1'b0;

			// slow receiver first, then slow sender, then full rate
			if (chunk < 2) begin
				send_idle_pct = 33;
				recv_idle_pct = 85;
			end else if (chunk < 4) begin
				send_idle_pct = 85;
				recv_idle_pct = 33;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end

			for (int n = 0; n < CHUNK_ITEMS; n++) begin
				// long receiver hold-off at full input rate fills the pipe
				if (chunk == 4 && n == 40)
					hold_cycles = 300;
				r32 = $urandom;
				case ($urandom_range(15))
					0: w = (r32 & ~B_MASK) | B_VAL;
					1: w = (r32 & ~BCOND_MASK) | BCOND_VAL;
					2: w = (r32 & ~CB_MASK) | CB_VAL;
					3: w = (r32 & ~CB_MASK) | TB_VAL;
					4: begin
						if ($urandom_range(3) == 0)
							w = (r32 & ~BREG_MASK) | BREG_VAL;
						else
							w = BREG_VAL | (32'($urandom_range(3)) << 21) | (32'h1F << 16)
								| (32'($urandom_range(31)) << 5);
					end
					5: begin
						if ($urandom_range(1) == 1)
							w = EXC_VAL | ((r32 & 32'hFFFF) << 5) | 32'h1;
						else
							w = (r32 & ~EXC_MASK) | EXC_VAL;
					end
					6: w = HINT_VAL | (r32 & ~HINT_MASK & 32'h0000_0FFF);
					7: w = BARRIER_VAL | (r32 & ~HINT_MASK & 32'h0000_0FFF);
					8: begin
						case ($urandom_range(2))
							0: w = DC_CVAU_VAL;
							1: w = IC_IVAU_VAL;
							default: w = DC_ZVA_VAL;
						endcase
						w = w | (r32 & ~SYS_RT_MASK);
					end
					9: w = (r32 & ~MSR_IMM_MASK) | MSR_IMM_VAL;
					13: w = {ID_EL1_READ_HI, r32[15:0]};
					14: w = (r32 & ~SYSREG_MASK) | SYSREG_VAL;
					15: w = r32;
					default: begin
						// known system registers, reads and writes mixed
						case ($urandom_range(16))
							0: w = MRS_CTR;
							1: w = MRS_DCZID;
							2: w = MRS_TPIDR;
							3: w = MRS_TPIDRRO;
							4: w = MSR_TPIDR;
							5: w = MRS_NZCV;
							6: w = MSR_NZCV;
							7: w = MRS_DAIF;
							8: w = MSR_DAIF;
							9: w = MRS_FPCR;
							10: w = MSR_FPCR;
							11: w = MRS_FPSR;
							12: w = MSR_FPSR;
							13: w = MRS_CNTFRQ;
							14: w = MRS_CNTPCT;
							15: w = MRS_CNTVCT;
							default: w = MRS_CNTVCTSS;
						endcase
						w = w | (r32 & ~SYS_RT_MASK);
					end
				endcase
				// operands biased toward zero tests and single bits
				case ($urandom_range(3))
					0: opv = '0;
					1: opv = {$urandom, 32'd0};
					2: opv = 64'd1 << $urandom_range(63);
					default: opv = {$urandom, $urandom};
				endcase
				send_insn(make_item(w, {$urandom, $urandom}, opv, 4'($urandom_range(15))));
			end
		end

		wait_for_results();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

FILE: files.f
src/abs_pkg.sv
src/abs_exec.sv
src/aarch64_branch_system_unit.sv
src/abs_checker.sv
verif/abs_checker.sv
verif/tb.sv
